### rtl/crm_pkg.sv
`timescale 1ns / 1ps

package crm_pkg;

    // Table geometry.
    localparam int STAGES            = 7;
    localparam int WINDOWS_PER_STAGE = 32;
    localparam int VALUE_BITS        = 32;
    localparam int SLOT_COUNT        = STAGES * WINDOWS_PER_STAGE;
    localparam int SLOT_W            = $clog2(SLOT_COUNT);

    // Field widths of the item ports.
    localparam int KIND_W  = 2;
    localparam int STAGE_W = 3;
    localparam int ENTRY_W = 5;

    // Item kinds; the fourth code is ignored.
    localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_XLATE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

    // One stored window, as it sits in the window memory.
    typedef struct packed {
        logic [VALUE_BITS-1:0] dest;
        logic [VALUE_BITS-1:0] source;
        logic [VALUE_BITS-1:0] length;
    } window_t;

    localparam int WINDOW_W = $bits(window_t);

    // Result of the shared window compare unit.
    typedef struct packed {
        logic                  hit;
        logic [VALUE_BITS-1:0] value;
    } match_t;

    // Sequencer status seen by the top level.
    typedef struct packed {
        logic walking;
        logic pending;
    } seq_stat_t;

    // Flat slot number of a (stage, entry) pair.
    function automatic logic [SLOT_W-1:0] slot_index(
        input logic [STAGE_W-1:0] stg,
        input logic [ENTRY_W-1:0] ent
    );
        return SLOT_W'(int'(stg) * WINDOWS_PER_STAGE + int'(ent));
    endfunction

endpackage

### rtl/chained_range_remap_min_core.sv
`timescale 1ns / 1ps
// Load, restart and ignored beats leave the block idle; the next beat is taken on the next cycle.
// A translate beat reads the windows of each stage in turn, compares each one with the current
// value as it leaves the memory, and registers its result in the finish state after the last stage.
// A match translates the value and skips the rest of its stage. No beat is taken until the result is
// registered, and that waits while an earlier result is still unaccepted.
// Reset clears all window enables, the running minimum (to all ones) and the result valid flag.

module chained_range_remap_min_core
    import crm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  logic [KIND_W-1:0]     kind,
    input  logic [STAGE_W-1:0]    stage,
    input  logic [ENTRY_W-1:0]    entry,
    input  logic                  entry_enable,
    input  logic [VALUE_BITS-1:0] dest_base,
    input  logic [VALUE_BITS-1:0] source_base,
    input  logic [VALUE_BITS-1:0] span_length,
    input  logic [VALUE_BITS-1:0] value,
    output logic                  result_valid,
    input  logic                  result_ready,
    output logic [VALUE_BITS-1:0] location,
    output logic [VALUE_BITS-1:0] lowest
);

    logic                  ram_wr_en;
    logic [SLOT_W-1:0]     ram_wr_addr;
    logic                  ram_rd_en;
    logic [SLOT_W-1:0]     ram_rd_addr;
    logic [WINDOW_W-1:0]   ram_rd_data;
    window_t               wr_window;
    logic [VALUE_BITS-1:0] cur_value;
    match_t                match;
    seq_stat_t             stat;

    assign wr_window.dest   = dest_base;
    assign wr_window.source = source_base;
    assign wr_window.length = span_length;

    // Window memory, all stages flattened.
    crm_ram #(
        .WIDTH (WINDOW_W),
        .DEPTH (SLOT_COUNT)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (wr_window),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Shared span compare and translate unit.
    crm_match u_match (
        .cur_value (cur_value),
        .window    (window_t'(ram_rd_data)),
        .result    (match)
    );

    crm_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .kind         (kind),
        .stage        (stage),
        .entry        (entry),
        .entry_enable (entry_enable),
        .value        (value),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .location     (location),
        .lowest       (lowest),
        .ram_wr_en    (ram_wr_en),
        .ram_wr_addr  (ram_wr_addr),
        .ram_rd_en    (ram_rd_en),
        .ram_rd_addr  (ram_rd_addr),
        .cur_value    (cur_value),
        .match        (match),
        .stat         (stat)
    );

    // The reported minimum never exceeds the location it comes with.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (lowest <= location))
        else $error("lowest above location");

    // Window loads happen only while no walk is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> !stat.walking)
        else $error("window write during walk");

    // No new beat is taken while a walk is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        stat.walking |-> !item_ready)
        else $error("item accepted during walk");

    // A pending compare always follows a memory read in the previous cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        stat.pending |-> $past(ram_rd_en))
        else $error("compare without read");

endmodule

### rtl/crm_ram.sv
`timescale 1ns / 1ps

module crm_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/crm_match.sv
`timescale 1ns / 1ps

module crm_match
    import crm_pkg::*;
(
    input  logic [VALUE_BITS-1:0] cur_value,
    input  window_t               window,
    output match_t                result
);

    logic [VALUE_BITS:0] diff;

    // The offset is taken one bit wider so that the sign bit shows a value
    // below the window start; the span end then never overflows.
    assign diff = {1'b0, cur_value} - {1'b0, window.source};

    always_comb
    begin
        result.hit   = !diff[VALUE_BITS] && (diff[VALUE_BITS-1:0] < window.length);
        result.value = window.dest + diff[VALUE_BITS-1:0];
    end

endmodule

### rtl/crm_seq.sv
`timescale 1ns / 1ps

module crm_seq
    import crm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Item channel.
    input  logic                  item_valid,
    output logic                  item_ready,
    input  logic [KIND_W-1:0]     kind,
    input  logic [STAGE_W-1:0]    stage,
    input  logic [ENTRY_W-1:0]    entry,
    input  logic                  entry_enable,
    input  logic [VALUE_BITS-1:0] value,
    // Result channel.
    output logic                  result_valid,
    input  logic                  result_ready,
    output logic [VALUE_BITS-1:0] location,
    output logic [VALUE_BITS-1:0] lowest,
    // Window memory control.
    output logic                  ram_wr_en,
    output logic [SLOT_W-1:0]     ram_wr_addr,
    output logic                  ram_rd_en,
    output logic [SLOT_W-1:0]     ram_rd_addr,
    // Shared compare unit.
    output logic [VALUE_BITS-1:0] cur_value,
    input  match_t                match,
    output seq_stat_t             stat
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_WALK   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    localparam logic [STAGE_W-1:0] LAST_STAGE = STAGE_W'(STAGES - 1);
    localparam logic [ENTRY_W-1:0] LAST_ENTRY = ENTRY_W'(WINDOWS_PER_STAGE - 1);

    logic [1:0]            state_reg, state_next;
    logic [SLOT_COUNT-1:0] valid_reg, valid_next;
    logic [STAGE_W-1:0]    iss_stage_reg, iss_stage_next;
    logic [ENTRY_W-1:0]    iss_entry_reg, iss_entry_next;
    logic                  iss_on_reg, iss_on_next;
    logic                  pend_reg, pend_next;
    logic [STAGE_W-1:0]    pend_stage_reg, pend_stage_next;
    logic [ENTRY_W-1:0]    pend_entry_reg, pend_entry_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic [VALUE_BITS-1:0] run_low_reg, run_low_next;
    logic                  out_valid_reg, out_valid_next;
    logic [VALUE_BITS-1:0] location_reg, location_next;
    logic [VALUE_BITS-1:0] lowest_reg, lowest_next;

    logic                  accept;
    logic                  load_ok;
    logic                  hit;
    logic [VALUE_BITS-1:0] new_low;

    assign item_ready = (state_reg == ST_IDLE);
    assign accept     = item_valid && item_ready;
    assign load_ok    = (int'(stage) < STAGES) && (int'(entry) < WINDOWS_PER_STAGE);

    // A pending compare hits only when its slot holds an enabled window.
    assign hit = pend_reg && valid_reg[slot_index(pend_stage_reg, pend_entry_reg)]
                 && match.hit;

    assign new_low = (value_reg < run_low_reg) ? value_reg : run_low_reg;

    assign ram_wr_en   = accept && (kind == KIND_LOAD) && load_ok;
    assign ram_wr_addr = slot_index(stage, entry);
    assign ram_rd_en   = (state_reg == ST_WALK) && iss_on_reg;
    assign ram_rd_addr = slot_index(iss_stage_reg, iss_entry_reg);
    assign cur_value   = value_reg;

    assign result_valid = out_valid_reg;
    assign location     = location_reg;
    assign lowest       = lowest_reg;

    assign stat.walking = (state_reg == ST_WALK);
    assign stat.pending = pend_reg;

    // Sequencer: issue one window read per cycle, compare it the next cycle.
    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        iss_stage_next  = iss_stage_reg;
        iss_entry_next  = iss_entry_reg;
        iss_on_next     = iss_on_reg;
        pend_next       = pend_reg;
        pend_stage_next = pend_stage_reg;
        pend_entry_next = pend_entry_reg;
        value_next      = value_reg;
        run_low_next    = run_low_reg;
        out_valid_next  = out_valid_reg && !result_ready;
        location_next   = location_reg;
        lowest_next     = lowest_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (kind)
                        KIND_LOAD:
                        begin
                            if (load_ok)
                            begin
                                valid_next[slot_index(stage, entry)] = entry_enable;
                            end
                        end
                        KIND_XLATE:
                        begin
                            value_next     = value;
                            iss_stage_next = '0;
                            iss_entry_next = '0;
                            iss_on_next    = 1'b1;
                            pend_next      = 1'b0;
                            state_next     = ST_WALK;
                        end
                        KIND_RESTART:
                        begin
                            run_low_next = '1;
                        end
                        default:
                        begin
                            run_low_next = run_low_reg;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if (hit)
                begin
                    // Translate and skip the rest of this stage; the read
                    // already in flight is dropped.
                    value_next     = match.value;
                    pend_next      = 1'b0;
                    iss_stage_next = pend_stage_reg + 1'b1;
                    iss_entry_next = '0;
                    iss_on_next    = (pend_stage_reg != LAST_STAGE);
                end
                else
                begin
                    pend_next       = iss_on_reg;
                    pend_stage_next = iss_stage_reg;
                    pend_entry_next = iss_entry_reg;
                    if (iss_on_reg)
                    begin
                        if (iss_entry_reg == LAST_ENTRY)
                        begin
                            iss_entry_next = '0;
                            iss_stage_next = iss_stage_reg + 1'b1;
                            iss_on_next    = (iss_stage_reg != LAST_STAGE);
                        end
                        else
                        begin
                            iss_entry_next = iss_entry_reg + 1'b1;
                        end
                    end
                end
                if (!iss_on_next && !pend_next)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_valid_next = 1'b1;
                    location_next  = value_reg;
                    lowest_next    = new_low;
                    run_low_next   = new_low;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            iss_on_reg    <= 1'b0;
            pend_reg      <= 1'b0;
            run_low_reg   <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            iss_on_reg    <= iss_on_next;
            pend_reg      <= pend_next;
            run_low_reg   <= run_low_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        iss_stage_reg  <= iss_stage_next;
        iss_entry_reg  <= iss_entry_next;
        pend_stage_reg <= pend_stage_next;
        pend_entry_reg <= pend_entry_next;
        value_reg      <= value_next;
        location_reg   <= location_next;
        lowest_reg     <= lowest_next;
    end

endmodule

### bench/chained_range_remap_min_core_test.sv
`timescale 1ns / 1ps

module chained_range_remap_min_core_test;
    import crm_pkg::*;

    // The fourth kind code is not named in the package; the block ignores it.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT  = 1_200_000;
    localparam int TAIL_CYCLES  = 240;
    localparam int PHASE_ITEMS  = 283;
    localparam int REPORT_LIMIT = 10;
    localparam int HOT_COUNT    = 64;

    typedef struct packed {
        logic [VALUE_BITS-1:0] location;
        logic [VALUE_BITS-1:0] lowest;
    } remap_result_t;

    // Shadow of the window table and running minimum, with the queue of
    // translate results still to come out of the block.
    class remap_scoreboard;
        bit                    win_on   [SLOT_COUNT];
        logic [VALUE_BITS-1:0] win_dest [SLOT_COUNT];
        logic [VALUE_BITS-1:0] win_src  [SLOT_COUNT];
        logic [VALUE_BITS-1:0] win_len  [SLOT_COUNT];
        logic [VALUE_BITS-1:0] run_min;
        remap_result_t         expected_results [$];
        int                    mismatches;

        function new();
            foreach (win_on[i])
            begin
                win_on[i]   = 1'b0;
                win_dest[i] = '0;
                win_src[i]  = '0;
                win_len[i]  = '0;
            end
            run_min    = '1;
            mismatches = 0;
        endfunction

        // Apply one accepted input beat to the shadow state.
        function void note_accepted(
            input logic [KIND_W-1:0]     k,
            input logic [STAGE_W-1:0]    stg,
            input logic [ENTRY_W-1:0]    ent,
            input logic                  en,
            input logic [VALUE_BITS-1:0] dst,
            input logic [VALUE_BITS-1:0] src,
            input logic [VALUE_BITS-1:0] len,
            input logic [VALUE_BITS-1:0] val
        );
            int                    slot;
            int                    s;
            int                    w;
            bit                    hit;
            logic [VALUE_BITS-1:0] v;
            logic [VALUE_BITS-1:0] off;
            remap_result_t         res;
            case (k)
                KIND_LOAD:
                begin
                    if (int'(stg) < STAGES && int'(ent) < WINDOWS_PER_STAGE)
                    begin
                        slot           = int'(stg) * WINDOWS_PER_STAGE + int'(ent);
                        win_on[slot]   = en;
                        win_dest[slot] = dst;
                        win_src[slot]  = src;
                        win_len[slot]  = len;
                    end
                end
                KIND_XLATE:
                begin
                    // Walk every stage; the lowest valid window holding the value wins.
                    // Since v >= source, the offset cannot wrap, so the span end
                    // is compared without overflow.
                    v = val;
                    for (s = 0; s < STAGES; s++)
                    begin
                        hit = 1'b0;
                        for (w = 0; w < WINDOWS_PER_STAGE && !hit; w++)
                        begin
                            slot = s * WINDOWS_PER_STAGE + w;
                            off  = v - win_src[slot];
                            if (win_on[slot] && v >= win_src[slot] && off < win_len[slot])
                            begin
                                v   = win_dest[slot] + off;
                                hit = 1'b1;
                            end
                        end
                    end
                    if (v < run_min)
                        run_min = v;
                    res.location = v;
                    res.lowest   = run_min;
                    expected_results.push_back(res);
                end
                KIND_RESTART:
                begin
                    run_min = '1;
                end
                default:
                begin
                end
            endcase
        endfunction

        // Compare one result beat against the oldest pending translate.
        function void check_result(
            input logic [VALUE_BITS-1:0] loc,
            input logic [VALUE_BITS-1:0] low
        );
            remap_result_t want;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("Unexpected result beat: location %h lowest %h", loc, low);
            end
            else
            begin
                want = expected_results.pop_front();
                if (want.location !== loc || want.lowest !== low)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("Result mismatch: location exp %h got %h, lowest exp %h got %h",
                                 want.location, loc, want.lowest, low);
                end
            end
        endfunction

        function int outstanding();
            return expected_results.size();
        endfunction

        function int failures();
            return mismatches + expected_results.size();
        endfunction
    endclass

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  item_valid   = 1'b0;
    logic                  item_ready;
    logic [KIND_W-1:0]     kind         = '0;
    logic [STAGE_W-1:0]    stage        = '0;
    logic [ENTRY_W-1:0]    entry        = '0;
    logic                  entry_enable = 1'b0;
    logic [VALUE_BITS-1:0] dest_base    = '0;
    logic [VALUE_BITS-1:0] source_base  = '0;
    logic [VALUE_BITS-1:0] span_length  = '0;
    logic [VALUE_BITS-1:0] value        = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    logic [VALUE_BITS-1:0] location;
    logic [VALUE_BITS-1:0] lowest;

    int                    idle_pct  = 0;
    int                    stall_pct = 0;
    logic [VALUE_BITS-1:0] hot_values [HOT_COUNT];
    remap_scoreboard       sb;

    chained_range_remap_min_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .kind         (kind),
        .stage        (stage),
        .entry        (entry),
        .entry_enable (entry_enable),
        .dest_base    (dest_base),
        .source_base  (source_base),
        .span_length  (span_length),
        .value        (value),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .location     (location),
        .lowest       (lowest)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Result side: random stalls change at the falling edge.
    always @(negedge clk)
    begin
        result_ready = ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            sb.check_result(location, lowest);
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("FAIL");
        $finish;
    end

    // Present one input beat and hold it until accepted. Called and
    // returning at a falling edge; valid stays high for a following beat.
    task automatic send_item(
        input logic [KIND_W-1:0]     k,
        input logic [STAGE_W-1:0]    stg,
        input logic [ENTRY_W-1:0]    ent,
        input logic                  en,
        input logic [VALUE_BITS-1:0] dst,
        input logic [VALUE_BITS-1:0] src,
        input logic [VALUE_BITS-1:0] len,
        input logic [VALUE_BITS-1:0] val
    );
        while ($urandom_range(99) < idle_pct)
        begin
            item_valid = 1'b0;
            @(negedge clk);
        end
        kind         = k;
        stage        = stg;
        entry        = ent;
        entry_enable = en;
        dest_base    = dst;
        source_base  = src;
        span_length  = len;
        value        = val;
        item_valid   = 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        sb.note_accepted(k, stg, ent, en, dst, src, len, val);
        @(negedge clk);
    endtask

    // Stop sending and wait until every translate result has come back.
    task automatic wait_drained();
        item_valid = 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Random beats. Window sources and destinations are drawn near values
    // seen before, so translations chain through several stages.
    task automatic run_random(input int target);
        int                    counted;
        int                    pick;
        logic [KIND_W-1:0]     k;
        logic [STAGE_W-1:0]    stg;
        logic [ENTRY_W-1:0]    ent;
        logic                  en;
        logic [VALUE_BITS-1:0] dst;
        logic [VALUE_BITS-1:0] src;
        logic [VALUE_BITS-1:0] len;
        logic [VALUE_BITS-1:0] val;
        counted = 0;
        while (counted < target)
        begin
            stg  = STAGE_W'($urandom_range(7));
            ent  = $urandom_range(1) ? ENTRY_W'($urandom_range(3))
                                     : ENTRY_W'($urandom_range(31));
            en   = ($urandom_range(99) < 85);
            dst  = $urandom;
            src  = $urandom;
            len  = $urandom;
            val  = $urandom;
            pick = $urandom_range(99);
            if (pick < 40)
            begin
                k = KIND_LOAD;
                if ($urandom_range(1))
                    src = hot_values[$urandom_range(HOT_COUNT - 1)] - $urandom_range(7);
                if ($urandom_range(1))
                    dst = hot_values[$urandom_range(HOT_COUNT - 1)] - $urandom_range(3);
                case ($urandom_range(9))
                    0: len = '0;
                    1: len = 1;
                    2, 3: len = $urandom_range(64, 2);
                    4, 5: len = $urandom_range(65536, 65);
                    6: ;
                    7:
                    begin
                        // Span running past the top of the value range.
                        src = 32'hFFFF_FFFF - $urandom_range(255);
                        len = $urandom_range(32'hFFFF_FFFF, 256);
                    end
                    default: len = $urandom_range(16, 1);
                endcase
                hot_values[$urandom_range(HOT_COUNT - 1)] = src;
                hot_values[$urandom_range(HOT_COUNT - 1)] = dst;
            end
            else if (pick < 88)
            begin
                k = KIND_XLATE;
                case ($urandom_range(9))
                    0: val = $urandom_range(1) ? '0 : '1;
                    1, 2: ;
                    default: val = hot_values[$urandom_range(HOT_COUNT - 1)]
                                   + $urandom_range(7);
                endcase
            end
            else if (pick < 94)
                k = KIND_RESTART;
            else
                k = KIND_UNUSED;
            send_item(k, stg, ent, en, dst, src, len, val);
            counted++;
        end
    endtask

    initial
    begin
        int p;
        int phase_idle  [4];
        int phase_stall [4];
        sb = new();
        foreach (hot_values[i])
            hot_values[i] = $urandom;
        hot_values[0] = '0;
        hot_values[1] = 32'hFFFF_FFF8;
        phase_idle  = '{0, 61, 0, 22};
        phase_stall = '{0, 0, 61, 22};

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Empty table: values pass unchanged; restart brings the minimum back up.
        send_item(KIND_XLATE, 3'($urandom), 5'($urandom), 1'($urandom),
                  $urandom, $urandom, $urandom, 32'h0000_0000);
        send_item(KIND_RESTART, 3'($urandom), 5'($urandom), 1'($urandom),
                  $urandom, $urandom, $urandom, $urandom);
        send_item(KIND_XLATE, 3'($urandom), 5'($urandom), 1'($urandom),
                  $urandom, $urandom, $urandom, 32'hFFFF_FFFF);
        // Two overlapping windows in stage 0; the lower entry wins.
        send_item(KIND_LOAD, 3'd0, 5'd0, 1'b1, 32'd100, 32'd10, 32'd5, $urandom);
        send_item(KIND_LOAD, 3'd0, 5'd1, 1'b1, 32'd500, 32'd12, 32'd10, $urandom);
        send_item(KIND_XLATE, 3'($urandom), 5'($urandom), 1'($urandom),
                  $urandom, $urandom, $urandom, 32'd10);
        send_item(KIND_XLATE, 3'($urandom), 5'($urandom), 1'($urandom),
                  $urandom, $urandom, $urandom, 32'd14);
        send_item(KIND_XLATE, 3'($urandom), 5'($urandom), 1'($urandom),
                  $urandom, $urandom, $urandom, 32'd15);
        send_item(KIND_XLATE, 3'($urandom), 5'($urandom), 1'($urandom),
                  $urandom, $urandom, $urandom, 32'd22);
        // Chain into stage 1, last entry, with a destination that wraps.
        send_item(KIND_LOAD, 3'd1, ENTRY_W'(WINDOWS_PER_STAGE - 1), 1'b1,
                  32'hFFFF_FFFE, 32'd100, 32'd10, $urandom);
        send_item(KIND_XLATE, 3'($urandom), 5'($urandom), 1'($urandom),
                  $urandom, $urandom, $urandom, 32'd13);
        // A zero-length window never matches.
        send_item(KIND_LOAD, STAGE_W'(STAGES - 1), ENTRY_W'(WINDOWS_PER_STAGE - 1), 1'b1,
                  32'd7, 32'd1, 32'd0, $urandom);
        send_item(KIND_XLATE, 3'($urandom), 5'($urandom), 1'($urandom),
                  $urandom, $urandom, $urandom, 32'd1);
        // A span reaching past the top covers up to the largest value.
        send_item(KIND_LOAD, 3'd2, 5'd5, 1'b1, 32'h0000_1000, 32'hFFFF_FFF0,
                  32'hFFFF_FFFF, $urandom);
        send_item(KIND_XLATE, 3'($urandom), 5'($urandom), 1'($urandom),
                  $urandom, $urandom, $urandom, 32'hFFFF_FFFF);
        // Catch-all window with the largest destination.
        send_item(KIND_LOAD, 3'd3, 5'd0, 1'b1, 32'hFFFF_FFFF, 32'h0000_0000,
                  32'hFFFF_FFFF, $urandom);
        send_item(KIND_XLATE, 3'($urandom), 5'($urandom), 1'($urandom),
                  $urandom, $urandom, $urandom, 32'd5);
        // Disable the first window; the overlapping one takes over.
        send_item(KIND_LOAD, 3'd0, 5'd0, 1'b0, $urandom, $urandom, $urandom, $urandom);
        send_item(KIND_XLATE, 3'($urandom), 5'($urandom), 1'($urandom),
                  $urandom, $urandom, $urandom, 32'd12);
        // Out-of-range stage and the unused kind are both ignored.
        send_item(KIND_LOAD, STAGE_W'(STAGES), 5'd31, 1'b1, 32'd5, 32'd0,
                  32'hFFFF_FFFF, $urandom);
        send_item(KIND_UNUSED, 3'($urandom), 5'($urandom), 1'($urandom),
                  $urandom, $urandom, $urandom, $urandom);
        send_item(KIND_RESTART, 3'($urandom), 5'($urandom), 1'($urandom),
                  $urandom, $urandom, $urandom, $urandom);
        send_item(KIND_LOAD, 3'd3, 5'd0, 1'b0, $urandom, $urandom, $urandom, $urandom);
        send_item(KIND_XLATE, 3'($urandom), 5'($urandom), 1'($urandom),
                  $urandom, $urandom, $urandom, 32'd3);
        wait_drained();

        // Random traffic under each idling mix, draining between phases.
        for (p = 0; p < 4; p++)
        begin
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            run_random(PHASE_ITEMS);
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.failures() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
